@@ rtl/core/palette_sprite_remap_blit_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for palette_sprite_remap_blit_core
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef PALETTE_SPRITE_REMAP_BLIT_CORE_ASSERT_SVH
`define PALETTE_SPRITE_REMAP_BLIT_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define PSRB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PSRB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PSRB_ASSERT(lbl, clk, rst_n, prop, msg)
`define PSRB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ rtl/core/psrb_pkg.sv @@
// ----------------------------------------------------------------------------
// psrb_pkg
// Shared types, constants and the shade ROM of the sprite blit core.
// ----------------------------------------------------------------------------
package psrb_pkg;

    localparam int TARGET_WIDTH_DEF  = 76;
    localparam int TARGET_HEIGHT_DEF = 96;
    localparam int REMAP_FIRST_DEF   = 192;
    localparam int QUEUE_DEPTH       = 4;

    localparam int ADDR_W  = 13;
    localparam int COORD_W = 8;
    localparam int COL_W   = 9;
    localparam int ROW_W   = 8;

    localparam logic KIND_PALETTE = 1'b0;
    localparam logic KIND_PIXEL   = 1'b1;

    localparam logic [2:0] REG_OFFSET_X     = 3'd0;
    localparam logic [2:0] REG_OFFSET_Y     = 3'd1;
    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd2;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd3;
    localparam logic [2:0] REG_OWNER        = 3'd4;

    localparam logic [1:0] OWNER_RED  = 2'd0;
    localparam logic [1:0] OWNER_BLUE = 2'd1;
    localparam logic [1:0] OWNER_GREY = 2'd2;

    typedef struct packed {
        logic                is_write;
        logic [7:0]          index;
        logic [23:0]         rgb;
        logic [COORD_W-1:0]  tx;
        logic [COORD_W-1:0]  ty;
        logic                last;
    } psrb_cmd_t;

    typedef struct packed {
        logic      valid;
        logic      full;
        psrb_cmd_t head;
    } psrb_q_status_t;

    // floor(255 * min(1, c * (0.60 + k/32))), rows by coefficient
    localparam logic [7:0] SHADE_ROM [0:5][0:15] = '{
        '{8'd153, 8'd160, 8'd168, 8'd176, 8'd184, 8'd192, 8'd200, 8'd208,
          8'd216, 8'd224, 8'd232, 8'd240, 8'd248, 8'd255, 8'd255, 8'd255},
        '{8'd18, 8'd19, 8'd20, 8'd21, 8'd22, 8'd23, 8'd24, 8'd25,
          8'd26, 8'd26, 8'd27, 8'd28, 8'd29, 8'd30, 8'd31, 8'd32},
        '{8'd12, 8'd12, 8'd13, 8'd14, 8'd14, 8'd15, 8'd16, 8'd16,
          8'd17, 8'd17, 8'd18, 8'd19, 8'd19, 8'd20, 8'd21, 8'd21},
        '{8'd27, 8'd28, 8'd30, 8'd31, 8'd33, 8'd34, 8'd36, 8'd37,
          8'd39, 8'd40, 8'd41, 8'd43, 8'd44, 8'd46, 8'd47, 8'd49},
        '{8'd84, 8'd88, 8'd92, 8'd97, 8'd101, 8'd106, 8'd110, 8'd114,
          8'd119, 8'd123, 8'd127, 8'd132, 8'd136, 8'd141, 8'd145, 8'd149},
        '{8'd130, 8'd136, 8'd143, 8'd150, 8'd157, 8'd163, 8'd170, 8'd177,
          8'd184, 8'd191, 8'd197, 8'd204, 8'd211, 8'd218, 8'd224, 8'd231}
    };

    function automatic logic [23:0] shade_rgb(input logic [1:0] owner,
                                              input logic [3:0] k);
        logic [23:0] res;
        case (owner)
            OWNER_RED: begin
                res = {SHADE_ROM[0][k], SHADE_ROM[1][k], SHADE_ROM[2][k]};
            end
            OWNER_BLUE: begin
                res = {SHADE_ROM[3][k], SHADE_ROM[4][k], SHADE_ROM[0][k]};
            end
            default: begin
                res = {SHADE_ROM[5][k], SHADE_ROM[5][k], SHADE_ROM[5][k]};
            end
        endcase
        return res;
    endfunction

endpackage

@@ rtl/core/psrb_front.sv @@
// ----------------------------------------------------------------------------
// psrb_front
// Accepts input beats, tracks source row/column, clips and queues commands.
// ----------------------------------------------------------------------------
module psrb_front #(
    parameter int TARGET_WIDTH  = psrb_pkg::TARGET_WIDTH_DEF,
    parameter int TARGET_HEIGHT = psrb_pkg::TARGET_HEIGHT_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,
    input  logic                s_tuser,
    input  logic [7:0]          offset_x,
    input  logic [7:0]          offset_y,
    input  logic [7:0]          frame_width,
    input  logic [7:0]          frame_height,
    input  logic                q_full,
    output logic                q_push,
    output psrb_pkg::psrb_cmd_t q_cmd
);
    import psrb_pkg::*;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             accept, disabled, col_wrap, row_wrap, visible, hit, last;
    logic [8:0]       padded;
    logic [9:0]       col_inc, tx;
    logic [8:0]       row_inc, ty;
    logic [7:0]       idx;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign idx      = s_tdata[7:0];

    always_comb begin
        disabled = (frame_width == 8'd0) || (frame_height == 8'd0);
        padded   = {1'b0, frame_width} + {8'd0, frame_width[0]};
        col_inc  = {1'b0, col_reg} + 10'd1;
        row_inc  = {1'b0, row_reg} + 9'd1;
        col_wrap = col_inc >= {1'b0, padded};
        row_wrap = row_inc >= {1'b0, frame_height};
        visible  = (col_reg < {1'b0, frame_width}) && (row_reg < frame_height);
        tx       = {2'b0, offset_x} + {1'b0, col_reg};
        ty       = {1'b0, offset_y} + {1'b0, row_reg};
        hit      = visible && (idx != 8'd0) && (tx < 10'(TARGET_WIDTH))
                   && (ty < 9'(TARGET_HEIGHT));
        last     = (col_reg == {1'b0, frame_width - 8'd1})
                   && (row_reg == frame_height - 8'd1);

        col_next = col_reg;
        row_next = row_reg;
        if (accept && s_tuser == KIND_PIXEL) begin
            if (disabled) begin
                col_next = '0;
                row_next = '0;
            end else if (col_wrap) begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_inc[ROW_W-1:0];
            end else begin
                col_next = col_inc[COL_W-1:0];
            end
        end

        q_cmd.is_write = (s_tuser == KIND_PALETTE);
        q_cmd.index    = idx;
        q_cmd.rgb      = {s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]};
        q_cmd.tx       = tx[COORD_W-1:0];
        q_cmd.ty       = ty[COORD_W-1:0];
        q_cmd.last     = last;
        q_push = accept && ((s_tuser == KIND_PALETTE) || (!disabled && hit));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

@@ rtl/core/psrb_queue.sv @@
// ----------------------------------------------------------------------------
// psrb_queue
// Short command FIFO decoupling the front and back halves.
// ----------------------------------------------------------------------------
module psrb_queue #(
    parameter int DEPTH = psrb_pkg::QUEUE_DEPTH
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  psrb_pkg::psrb_cmd_t       push_cmd,
    input  logic                      pop,
    output psrb_pkg::psrb_q_status_t  status,
    output logic [$clog2(DEPTH+1)-1:0] level
);
    import psrb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    psrb_cmd_t         entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0]  level_reg, level_next;
    logic              do_push, do_pop;

    assign status.valid = (level_reg != '0);
    assign status.full  = (level_reg == LVL_W'(DEPTH));
    assign status.head  = entry_reg[rd_ptr_reg];
    assign level        = level_reg;

    always_comb begin
        do_push     = push && !status.full;
        do_pop      = pop && status.valid;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        level_next = level_reg;
        if (do_push && !do_pop) begin
            level_next = level_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/core/psrb_back.sv @@
// ----------------------------------------------------------------------------
// psrb_back
// Palette memory, remap shading, address generation and output register.
// ----------------------------------------------------------------------------
module psrb_back #(
    parameter int TARGET_WIDTH = psrb_pkg::TARGET_WIDTH_DEF,
    parameter int REMAP_FIRST  = psrb_pkg::REMAP_FIRST_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  psrb_pkg::psrb_q_status_t q_status,
    output logic                     q_pop,
    input  logic [1:0]               owner,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [39:0]              m_tdata,
    output logic                     m_tlast
);
    import psrb_pkg::*;

    localparam int PROD_W = ADDR_W + 4 + 1;

    logic [23:0]       pal_mem [256];
    logic [23:0]       rd_data_reg;
    logic              a_valid_reg, a_valid_next;
    logic              a_remap_reg, a_last_reg;
    logic [23:0]       a_shade_reg;
    logic [ADDR_W-1:0] a_addr_reg;
    logic              m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0] m_addr_reg;
    logic [23:0]       m_rgb_reg;
    logic              m_last_reg;
    logic              a_adv, pop_pix;
    logic [8:0]        idx_ext, idx_rel;
    logic              remap;
    logic [PROD_W-1:0] addr_full;
    psrb_cmd_t         head;

    assign head  = q_status.head;
    assign a_adv = !m_valid_reg || m_tready;
    assign q_pop = q_status.valid && (head.is_write || !a_valid_reg || a_adv);
    assign pop_pix = q_pop && !head.is_write;

    always_comb begin
        idx_ext   = {1'b0, head.index};
        idx_rel   = idx_ext - 9'(REMAP_FIRST);
        remap     = (idx_ext >= 9'(REMAP_FIRST)) && (idx_rel <= 9'd15);
        addr_full = PROD_W'(head.ty) * PROD_W'(TARGET_WIDTH) + PROD_W'(head.tx);

        a_valid_next = a_valid_reg;
        if (pop_pix) begin
            a_valid_next = 1'b1;
        end else if (a_adv) begin
            a_valid_next = 1'b0;
        end
        m_valid_next = a_adv ? a_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && head.is_write) begin
            pal_mem[head.index] <= head.rgb;
        end
        if (pop_pix) begin
            rd_data_reg <= pal_mem[head.index];
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_pix) begin
            a_remap_reg <= remap;
            a_shade_reg <= shade_rgb(owner, idx_rel[3:0]);
            a_addr_reg  <= addr_full[ADDR_W-1:0];
            a_last_reg  <= head.last;
        end
        if (a_adv && a_valid_reg) begin
            m_addr_reg <= a_addr_reg;
            m_rgb_reg  <= a_remap_reg ? a_shade_reg : rd_data_reg;
            m_last_reg <= a_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {3'b000, m_rgb_reg[7:0], m_rgb_reg[15:8], m_rgb_reg[23:16],
                       m_addr_reg};

endmodule

@@ rtl/core/palette_sprite_remap_blit_core.sv @@
// ----------------------------------------------------------------------------
// palette_sprite_remap_blit_core
// Palette sprite blitter with owner color remap into a fixed target texture.
// ----------------------------------------------------------------------------
// Takes one beat per clock while the queue is not full: palette writes
// (tuser 0) load the 256-entry RGB palette, pixel bytes (tuser 1) arrive
// row-major with rows padded to even width. Each visible, non-zero,
// unclipped pixel gives one result beat with its texel address and color;
// indices REMAP_FIRST..REMAP_FIRST+15 take the owner shade instead of the
// palette. Sustained rate is one beat per cycle unless the output stalls;
// results pass queue entry, palette read and output registers. A four-entry
// command queue lets input continue while the output is stalled. The user
// must write configuration only while idle; the core does not enforce it.
// ----------------------------------------------------------------------------
`include "palette_sprite_remap_blit_core_assert.svh"

module palette_sprite_remap_blit_core #(
    parameter int TARGET_WIDTH  = psrb_pkg::TARGET_WIDTH_DEF,
    parameter int TARGET_HEIGHT = psrb_pkg::TARGET_HEIGHT_DEF,
    parameter int REMAP_FIRST   = psrb_pkg::REMAP_FIRST_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // color_index, red_in, green_in, blue_in
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // texel_address, red_out, green_out, blue_out
    output logic        m_tlast,   // frame_end
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata
);
    import psrb_pkg::*;

    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    logic [7:0]     offset_x_reg, offset_y_reg, width_reg, height_reg;
    logic [1:0]     owner_reg;
    logic           q_push, q_pop;
    psrb_cmd_t      q_cmd;
    psrb_q_status_t q_status;
    logic [LVL_W-1:0] q_level;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            owner_reg    <= OWNER_GREY;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_OFFSET_X:     offset_x_reg <= cfg_wdata;
                REG_OFFSET_Y:     offset_y_reg <= cfg_wdata;
                REG_FRAME_WIDTH:  width_reg    <= cfg_wdata;
                REG_FRAME_HEIGHT: height_reg   <= cfg_wdata;
                REG_OWNER:        owner_reg    <= cfg_wdata[1:0];
                default: begin
                end
            endcase
        end
    end

    psrb_front #(
        .TARGET_WIDTH  (TARGET_WIDTH),
        .TARGET_HEIGHT (TARGET_HEIGHT)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .offset_x     (offset_x_reg),
        .offset_y     (offset_y_reg),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .q_full       (q_status.full),
        .q_push       (q_push),
        .q_cmd        (q_cmd)
    );

    psrb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .status   (q_status),
        .level    (q_level)
    );

    psrb_back #(
        .TARGET_WIDTH (TARGET_WIDTH),
        .REMAP_FIRST  (REMAP_FIRST)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .q_pop    (q_pop),
        .owner    (owner_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    `PSRB_ASSERT(a_push_clipped_x, aclk, aresetn,
        (q_push && !q_cmd.is_write) |-> (32'(q_cmd.tx) < TARGET_WIDTH), "pixel past width")
    `PSRB_ASSERT(a_pop_nonempty, aclk, aresetn,
        q_pop |-> (q_level != '0), "pop from empty queue")
    `PSRB_ASSERT(a_addr_range, aclk, aresetn,
        m_tvalid |-> ((TARGET_WIDTH * TARGET_HEIGHT > 8192) ||
        (32'(m_tdata[12:0]) < TARGET_WIDTH * TARGET_HEIGHT)), "address out of texture")

endmodule
